>>> rtl/core/rau_pkg.sv
`default_nettype none
package rau_pkg;
    localparam int unsigned WIDTH = 32;
    localparam int unsigned PW = 2 * WIDTH + 1;
    localparam int unsigned CW = $clog2(PW + 1);

    typedef enum logic [2:0] {
        FN_ADD = 3'd0,
        FN_SUB = 3'd1,
        FN_MUL = 3'd2,
        FN_DIV = 3'd3,
        FN_CMP = 3'd4
    } t_func;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_ERR = 2'd1,
        ST_OVF = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE, S_MAG, S_MUL1, S_MUL2, S_MUL3, S_SUM, S_CHK, S_GEVEN,
        S_AODD, S_BODD, S_BSUB, S_GSHL, S_DIVN, S_DIVD, S_PACK, S_OUT
    } t_state;

    typedef struct packed {
        logic [2:0]         func;
        logic [WIDTH-1:0]   a_num;
        logic [WIDTH-1:0]   a_den;
        logic [WIDTH-1:0]   b_num;
        logic [WIDTH-1:0]   b_den;
    } t_req;

    typedef struct packed {
        logic [WIDTH-1:0]   res_num;
        logic [WIDTH-2:0]   res_den;
        logic [1:0]         order;
        logic [1:0]         status;
    } t_rsp;
endpackage
`default_nettype wire

>>> rtl/core/rau_if.sv
`default_nettype none
interface rau_req_if;
    import rau_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rau_rsp_if;
    import rau_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/core/rau_div.sv
`default_nettype none
// restoring divider, one quotient bit per cycle
module rau_div (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [rau_pkg::PW-1:0] i_num,
    input  wire logic [rau_pkg::PW-1:0] i_den,
    output logic                       o_done,
    output logic [rau_pkg::PW-1:0]     o_quo
);
    import rau_pkg::*;
    logic [PW-1:0] r_n, r_q, r_d, r_r;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic [PW:0]   w_sh;
    logic [PW:0]   w_df;

    assign w_sh = {r_r, r_n[PW-1]};
    assign w_df = w_sh - {1'b0, r_d};
    assign o_quo = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(PW);
            end else if (r_busy) begin
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
                r_cnt <= r_cnt - CW'(1);
            end
        end
        if (i_start) begin
            r_n <= i_num;
            r_d <= i_den;
            r_q <= '0;
            r_r <= '0;
        end else if (r_busy) begin
            r_n <= {r_n[PW-2:0], 1'b0};
            if (!w_df[PW]) begin
                r_r <= w_df[PW-1:0];
                r_q <= {r_q[PW-2:0], 1'b1};
            end else begin
                r_r <= w_sh[PW-1:0];
                r_q <= {r_q[PW-2:0], 1'b0};
            end
        end
    end
endmodule
`default_nettype wire

>>> rtl/core/rational_arithmetic_unit.sv
`default_nettype none
// A zero denominator, divide by zero or unused code ends after the magnitude step; compare
// or a zero numerator ends after the cross products; otherwise setup, the data-dependent
// binary GCD loop, two divisions and pack.
// Throughput: one request at a time; the next is accepted after the response leaves.
// Reset: synchronous, active low; returns the sequencer to idle.
module rational_arithmetic_unit (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    rau_req_if.sink   i_req,
    rau_rsp_if.source o_rsp
);
    import rau_pkg::*;

    t_state r_st, n_st;
    t_req   r_q;
    t_rsp   r_out;
    logic [WIDTH-1:0] r_an, r_ad, r_bn, r_bd;
    logic [PW-1:0]    r_nm, r_dm, r_x, r_y;
    logic             r_nneg, r_dneg, r_tneg, r_neg;
    logic [CW-1:0]    r_k;

    logic [WIDTH-1:0]   w_m0, w_m1;
    logic [2*WIDTH-1:0] w_p;
    logic               w_gt, w_add;
    logic [PW-1:0]      w_opa, w_opb, w_alu;
    logic               w_start, w_done;
    logic [PW-1:0]      w_dnum, w_quo, w_lim;
    logic               w_err, w_nfit, w_dfit;

    function automatic logic [WIDTH-1:0] mag(input logic [WIDTH-1:0] v);
        return v[WIDTH-1] ? (~v + WIDTH'(1)) : v;
    endfunction

    assign w_p   = w_m0 * w_m1;
    assign w_gt  = r_x > r_y;
    assign w_opa = w_gt ? r_x : r_y;
    assign w_opb = w_gt ? r_y : r_x;
    assign w_add = (r_st == S_SUM) && (r_nneg == r_tneg);
    assign w_alu = w_add ? (w_opa + w_opb) : (w_opa - w_opb);
    assign w_lim = PW'(1) << (WIDTH - 1);
    assign w_err = r_q.a_den == '0 || r_q.b_den == '0
                   || (r_q.func == FN_DIV && r_q.b_num == '0);
    assign w_nfit = r_nm < w_lim || (r_neg && r_nm == w_lim);
    assign w_dfit = r_dm < w_lim;

    assign i_req.ready = (r_st == S_IDLE);
    assign o_rsp.valid = (r_st == S_OUT);
    assign o_rsp.data  = r_out;

    rau_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_start),
        .i_num  (w_dnum),
        .i_den  (r_x),
        .o_done (w_done),
        .o_quo  (w_quo)
    );

    always_comb begin
        unique case (r_st)
            S_MUL1: begin
                w_m0 = r_ad;
                w_m1 = (r_q.func == FN_DIV) ? r_bn : r_bd;
            end
            S_MUL2: begin
                w_m0 = r_an;
                w_m1 = (r_q.func == FN_MUL) ? r_bn : r_bd;
            end
            default: begin
                w_m0 = r_bn;
                w_m1 = r_ad;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= S_IDLE;
        else          r_st <= n_st;
    end

    always_comb begin
        n_st    = r_st;
        w_start = 1'b0;
        w_dnum  = r_nm;
        unique case (r_st)
            S_IDLE:  if (i_req.valid) n_st = S_MAG;
            S_MAG:   if (r_q.func > FN_CMP || w_err) n_st = S_OUT;
                     else n_st = S_MUL1;
            S_MUL1:  n_st = S_MUL2;
            S_MUL2:  if (r_q.func == FN_MUL || r_q.func == FN_DIV) n_st = S_CHK;
                     else n_st = S_MUL3;
            S_MUL3:  n_st = S_SUM;
            S_SUM:   n_st = S_CHK;
            S_CHK:   if (r_nm == '0 || r_q.func == FN_CMP) n_st = S_OUT;
                     else n_st = S_GEVEN;
            S_GEVEN: if (r_x[0] || r_y[0]) n_st = S_AODD;
            S_AODD:  if (r_x[0]) n_st = S_BODD;
            S_BODD:  if (r_y[0]) n_st = S_BSUB;
            S_BSUB:  if (r_x == r_y) n_st = S_GSHL;
                     else n_st = S_BODD;
            S_GSHL: if (r_k == '0) begin
                    n_st = S_DIVN;
                    w_start = 1'b1;
                end
            S_DIVN: if (w_done) begin
                    n_st = S_DIVD;
                    w_start = 1'b1;
                    w_dnum = r_dm;
                end
            S_DIVD:  if (w_done) n_st = S_PACK;
            S_PACK:  n_st = S_OUT;
            S_OUT:   if (o_rsp.ready) n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        unique case (r_st)
            S_IDLE: begin
                r_q   <= i_req.data;
                r_out <= '{res_num: '0, res_den: (WIDTH-1)'(1), order: 2'd0,
                           status: ST_OK};
            end
            S_MAG: begin
                r_an <= mag(r_q.a_num);
                r_ad <= mag(r_q.a_den);
                r_bn <= mag(r_q.b_num);
                r_bd <= mag(r_q.b_den);
                if (r_q.func <= FN_CMP && w_err) r_out.status <= ST_ERR;
            end
            S_MUL1: begin
                r_dm   <= PW'(w_p);
                r_dneg <= r_q.a_den[WIDTH-1] ^ ((r_q.func == FN_DIV) ? r_q.b_num[WIDTH-1]
                                                                     : r_q.b_den[WIDTH-1]);
            end
            S_MUL2: begin
                r_nm   <= PW'(w_p);
                r_y    <= PW'(w_p);
                r_nneg <= r_q.a_num[WIDTH-1] ^ ((r_q.func == FN_MUL) ? r_q.b_num[WIDTH-1]
                                                                     : r_q.b_den[WIDTH-1]);
            end
            S_MUL3: begin
                r_x    <= PW'(w_p);
                r_tneg <= r_q.b_num[WIDTH-1] ^ r_q.a_den[WIDTH-1] ^ (r_q.func != FN_ADD);
            end
            S_SUM: begin
                r_nm <= w_alu;
                if (!w_add && w_gt) r_nneg <= r_tneg;
            end
            S_CHK: begin
                r_x   <= r_nm;
                r_y   <= r_dm;
                r_k   <= '0;
                r_neg <= r_nneg ^ r_dneg;
                if (r_q.func == FN_CMP && r_nm != '0)
                    r_out.order <= (r_nneg ^ r_dneg) ? 2'b11 : 2'b01;
            end
            S_GEVEN: if (!(r_x[0] || r_y[0])) begin
                r_x <= r_x >> 1;
                r_y <= r_y >> 1;
                r_k <= r_k + CW'(1);
            end
            S_AODD: if (!r_x[0]) r_x <= r_x >> 1;
            S_BODD: if (!r_y[0]) r_y <= r_y >> 1;
            S_BSUB: begin
                if (w_gt) r_x <= r_y;
                r_y <= w_alu;
            end
            S_GSHL: if (r_k != '0) begin
                r_x <= r_x << 1;
                r_k <= r_k - CW'(1);
            end
            S_DIVN: if (w_done) r_nm <= w_quo;
            S_DIVD: if (w_done) r_dm <= w_quo;
            S_PACK: begin
                if (w_nfit && w_dfit) begin
                    r_out.res_num <= r_neg ? (~r_nm[WIDTH-1:0] + WIDTH'(1)) : r_nm[WIDTH-1:0];
                    r_out.res_den <= r_dm[WIDTH-2:0];
                end else begin
                    r_out.status <= ST_OVF;
                end
            end
            S_OUT: ;
        endcase
    end
endmodule
`default_nettype wire
